### rtl/mps_pkg.sv
`timescale 1ns / 1ps

package mps_pkg;

   // Fixed field widths
   localparam int COORD_BITS   = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_ADDR_W   = 2;
   localparam int SHADE_W      = 8;
   localparam int COUNT_OUT_W  = 9;

   // Defaults for the top-level parameters
   localparam int MAX_ITER_DEF  = 500;
   localparam int FRAC_BITS_DEF = 28;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_COLS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_ROWS = 2'd1;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] IMAGE_COLS_RST = 13'd5400;
   localparam logic [CSR_DATA_W-1:0] IMAGE_ROWS_RST = 13'd4800;

   // Scale factors (times 10) of the plane window
   localparam int SPAN_X_X10 = 27;
   localparam int SPAN_Y_X10 = 24;

   // Largest coordinate numerator: 27 * 8191 fits 18 bits
   localparam int NUMER_W = 18;
   // Largest divisor: 10 * 8191 fits 17 bits
   localparam int DENOM_W = 17;

   // 4 * 65025, right side factor of the shade test
   localparam int SHADE_RHS_K = 260100;

endpackage

### rtl/mps_fifo.sv
`timescale 1ns / 1ps

// Two-entry queue between the coordinate front and the iteration back
module mps_fifo #(
   parameter int W = 68
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/mps_front.sv
`timescale 1ns / 1ps

// Front: holds the image size, takes a pixel, maps it to c with a
// bit-serial restoring divider (column first, then row) and queues c.
module mps_front #(
   parameter int FRAC_BITS = mps_pkg::FRAC_BITS_DEF,
   parameter int ZW        = FRAC_BITS + 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mps_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [mps_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_push,
   input  logic [mps_pkg::COORD_BITS-1:0]  req_pixel_row,
   input  logic [mps_pkg::COORD_BITS-1:0]  req_pixel_col,
   output logic                            req_full,
   output logic                            q_push,
   output logic [2*ZW-1:0]                 q_data,
   input  logic                            q_full
);

   localparam int NW    = mps_pkg::NUMER_W + FRAC_BITS;
   localparam int DW    = mps_pkg::DENOM_W;
   localparam int CNT_W = $clog2(NW);
   localparam logic [NW-1:0] CAP       = NW'(64'd6 << FRAC_BITS);
   localparam logic [ZW-1:0] X_ORIGIN  = ZW'((64'd21 << FRAC_BITS) / 64'd10);
   localparam logic [ZW-1:0] Y_ORIGIN  = ZW'((64'd12 << FRAC_BITS) / 64'd10);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_PUSH
   } state_type;

   state_type                      state_ff;
   logic [mps_pkg::CSR_DATA_W-1:0] cols_ff, rows_ff;
   logic [mps_pkg::COORD_BITS-1:0] row_ff;
   logic                           phase_ff;   // 0: column, 1: row
   logic [NW-1:0]                  num_ff, quo_ff;
   logic [DW-1:0]                  rem_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic [ZW-1:0]                  cr_ff, ci_ff;

   logic [DW-1:0]                  den;
   logic [DW:0]                    r2;
   logic                           ge;
   logic [DW:0]                    r2_sub;
   logic [NW-1:0]                  q_fin, q_sat;
   logic [ZW-1:0]                  coord;
   logic [mps_pkg::CSR_DATA_W-1:0] cols_eff, rows_eff;

   assign req_full = (state_ff != S_IDLE);
   assign q_push   = (state_ff == S_PUSH);
   assign q_data   = {ci_ff, cr_ff};

   // divisor: 10 * size, a zero size counts as one
   always_comb begin
      cols_eff = (cols_ff == '0) ? mps_pkg::CSR_DATA_W'(1) : cols_ff;
      rows_eff = (rows_ff == '0) ? mps_pkg::CSR_DATA_W'(1) : rows_ff;
      den = phase_ff ? DW'(rows_eff) * DW'(10) : DW'(cols_eff) * DW'(10);
   end

   // one quotient bit per cycle
   always_comb begin
      r2     = {rem_ff, num_ff[NW-1]};
      ge     = (r2 >= {1'b0, den});
      r2_sub = r2 - {1'b0, den};
      q_fin  = {quo_ff[NW-2:0], ge};
      q_sat  = (q_fin > CAP) ? CAP : q_fin;
      coord  = ZW'(q_sat) - (phase_ff ? Y_ORIGIN : X_ORIGIN);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= mps_pkg::IMAGE_COLS_RST;
         rows_ff <= mps_pkg::IMAGE_ROWS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            mps_pkg::REG_IMAGE_COLS: cols_ff <= csr_wdata;
            mps_pkg::REG_IMAGE_ROWS: rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_push) begin
                  row_ff   <= req_pixel_row;
                  num_ff   <= {mps_pkg::NUMER_W'(req_pixel_col) *
                               mps_pkg::NUMER_W'(mps_pkg::SPAN_X_X10),
                               FRAC_BITS'(0)};
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  phase_ff <= 1'b0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= ge ? r2_sub[DW-1:0] : r2[DW-1:0];
               quo_ff <= q_fin;
               num_ff <= {num_ff[NW-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(NW-1)) begin
                  cnt_ff <= '0;
                  rem_ff <= '0;
                  quo_ff <= '0;
                  if (!phase_ff) begin
                     cr_ff    <= coord;
                     phase_ff <= 1'b1;
                     num_ff   <= {mps_pkg::NUMER_W'(row_ff) *
                                  mps_pkg::NUMER_W'(mps_pkg::SPAN_Y_X10),
                                  FRAC_BITS'(0)};
                  end else begin
                     ci_ff    <= coord;
                     state_ff <= S_PUSH;
                  end
               end
            end
            S_PUSH: begin
               if (!q_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/mps_back.sv
`timescale 1ns / 1ps

// Back: runs z = z*z + c (multiply cycle, then test/update cycle),
// then an 8-step search for the shade, then holds the result.
module mps_back #(
   parameter int MAX_ITER  = mps_pkg::MAX_ITER_DEF,
   parameter int FRAC_BITS = mps_pkg::FRAC_BITS_DEF,
   parameter int ZW        = FRAC_BITS + 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  logic [2*ZW-1:0]                   q_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [mps_pkg::SHADE_W-1:0]       rsp_shade,
   output logic [mps_pkg::COUNT_OUT_W-1:0]   rsp_escape_count
);

   localparam int PW = FRAC_BITS + 10;
   localparam int CW = $clog2(MAX_ITER + 1);
   localparam logic signed [PW:0] LIMIT = (PW+1)'(64'd4 << FRAC_BITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_UPD,
      S_SHADE,
      S_DONE
   } state_type;

   state_type                       state_ff;
   logic signed [ZW-1:0]            cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [PW-1:0]            sr_ff, si_ff, pr_ff;
   logic [CW-1:0]                   t_ff;
   logic [2:0]                      bit_ff;
   logic [mps_pkg::SHADE_W-1:0]     best_ff;
   logic                            out_valid_ff;
   logic [mps_pkg::SHADE_W-1:0]     out_shade_ff;
   logic [mps_pkg::COUNT_OUT_W-1:0] out_count_ff;

   logic signed [2*ZW-1:0]          p_rr, p_ii, p_ri;
   logic signed [PW:0]              mag;
   logic [mps_pkg::SHADE_W-1:0]     cand;
   logic [9:0]                      d;
   logic [31:0]                     lhs, rhs;

   assign q_pop            = (state_ff == S_IDLE) && !q_empty;
   assign rsp_empty        = !out_valid_ff;
   assign rsp_shade        = out_shade_ff;
   assign rsp_escape_count = out_count_ff;

   // products; floor shift is a part-select of the exact product
   always_comb begin
      p_rr = zr_ff * zr_ff;
      p_ii = zi_ff * zi_ff;
      p_ri = zr_ff * zi_ff;
      mag  = {sr_ff[PW-1], sr_ff} + {si_ff[PW-1], si_ff};
   end

   // shade test: (2s-1)^2 * MAX_ITER <= 260100 * t
   always_comb begin
      cand = best_ff | (mps_pkg::SHADE_W'(1) << bit_ff);
      d    = {1'b0, cand, 1'b0} - 10'd1;
      lhs  = 32'(d) * 32'(d) * 32'(MAX_ITER);
      rhs  = 32'(mps_pkg::SHADE_RHS_K) * 32'(t_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // the done state reloads the holding register itself
         if (rsp_pop && out_valid_ff && state_ff != S_DONE) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  cr_ff    <= q_data[ZW-1:0];
                  zr_ff    <= q_data[ZW-1:0];
                  ci_ff    <= q_data[2*ZW-1:ZW];
                  zi_ff    <= q_data[2*ZW-1:ZW];
                  t_ff     <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               sr_ff    <= p_rr[FRAC_BITS +: PW];
               si_ff    <= p_ii[FRAC_BITS +: PW];
               pr_ff    <= p_ri[FRAC_BITS-1 +: PW];
               state_ff <= S_UPD;
            end
            S_UPD: begin
               bit_ff  <= 3'd7;
               best_ff <= '0;
               if (mag > LIMIT) begin
                  state_ff <= S_SHADE;
               end else begin
                  zr_ff <= ZW'(sr_ff - si_ff) + cr_ff;
                  zi_ff <= ZW'(pr_ff) + ci_ff;
                  t_ff  <= t_ff + 1'b1;
                  state_ff <= (t_ff == CW'(MAX_ITER - 1)) ? S_SHADE : S_MUL;
               end
            end
            S_SHADE: begin
               if (lhs <= rhs) begin
                  best_ff <= cand;
               end
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == 3'd0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // wait while the previous result is still held
               if (!out_valid_ff || rsp_pop) begin
                  out_valid_ff <= 1'b1;
                  out_shade_ff <= (t_ff == CW'(MAX_ITER)) ? '0 : best_ff;
                  out_count_ff <= mps_pkg::COUNT_OUT_W'(t_ff);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/mandelbrot_pixel_shade.sv
`timescale 1ns / 1ps

// Channel  Ports                                        Transfer
// req      req_push, req_full, req_pixel_row/col         push & !full
// rsp      rsp_pop, rsp_empty, rsp_shade/escape_count    pop & !empty
// csr      csr_we, csr_addr, csr_wdata                   csr_we
//
// Front: bit-serial divider; it takes a new pixel only once the last one is queued.
// Back: multiply, then test/update for each iteration, then the shade search;
// for pixels that escape late, the iteration loop sets the rate.
// Reset is synchronous; image size returns to 5400 x 4800.
// A two-entry queue parts front and back; a held result stalls the back, and the front once the queue is full.
module mandelbrot_pixel_shade #(
   parameter int MAX_ITER  = mps_pkg::MAX_ITER_DEF,
   parameter int FRAC_BITS = mps_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mps_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mps_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_push,
   input  logic [mps_pkg::COORD_BITS-1:0]    req_pixel_row,
   input  logic [mps_pkg::COORD_BITS-1:0]    req_pixel_col,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [mps_pkg::SHADE_W-1:0]       rsp_shade,
   output logic [mps_pkg::COUNT_OUT_W-1:0]   rsp_escape_count
);

   localparam int ZW = FRAC_BITS + 6;

   logic            fq_push, fq_full, fq_pop, fq_empty;
   logic [2*ZW-1:0] fq_wdata, fq_rdata;

   mps_front #(
      .FRAC_BITS (FRAC_BITS),
      .ZW        (ZW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_pixel_row (req_pixel_row),
      .req_pixel_col (req_pixel_col),
      .req_full      (req_full),
      .q_push        (fq_push),
      .q_data        (fq_wdata),
      .q_full        (fq_full)
   );

   mps_fifo #(
      .W (2*ZW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_wdata),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_rdata),
      .empty     (fq_empty)
   );

   mps_back #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS),
      .ZW        (ZW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (fq_empty),
      .q_pop            (fq_pop),
      .q_data           (fq_rdata),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_shade        (rsp_shade),
      .rsp_escape_count (rsp_escape_count)
   );

endmodule
